/* src/irtg_pkg.sv */
`default_nettype none

package irtg_pkg;

    localparam int DIM_W      = 10;
    localparam int KERN_W     = 3;
    localparam int PAD_W      = 3;
    localparam int ROW_W      = 21;
    localparam int ADDR_W     = 48;
    localparam int BUF_W      = 11;
    localparam int SIGN_W     = 12;
    localparam int PLANE_W    = 21;
    localparam int KWP_W      = 24;
    localparam int MUL_B_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 5;
    localparam int DIV_STEPS  = 21;
    localparam int CALC_STEPS = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_HEIGHT = 3'd0,
        CFG_IMAGE_WIDTH  = 3'd1,
        CFG_PAD_ROWS     = 3'd2,
        CFG_PAD_COLS     = 3'd3,
        CFG_KERN_HEIGHT  = 3'd4,
        CFG_KERN_WIDTH   = 3'd5,
        CFG_SOURCE_BASE  = 3'd6,
        CFG_DEST_BASE    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_PUT   = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_BOUNDS,
        OP_MUL_CH,
        OP_MUL_CHW,
        OP_MUL_RW,
        OP_ADD_FT,
        OP_ADD_FS,
        OP_MUL_PLANE,
        OP_MUL_CP,
        OP_MUL_CPKW,
        OP_MUL_CPKH,
        OP_MUL_U,
        OP_ADD_PT,
        OP_MUL_KWP,
        OP_MUL_V,
        OP_ADD_PD,
        OP_FILL,
        OP_NEXT_PUT
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0]  image_height;
        logic [DIM_W-1:0]  image_width;
        logic [PAD_W-1:0]  pad_rows;
        logic [PAD_W-1:0]  pad_cols;
        logic [KERN_W-1:0] kern_height;
        logic [KERN_W-1:0] kern_width;
        logic [ADDR_W-1:0] source_base;
        logic [ADDR_W-1:0] dest_base;
    } cfg_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [BUF_W-1:0]  buffer_offset;
        logic [BUF_W-1:0]  length;
        logic              last;
    } desc_t;

    function automatic op_t calc_op(input logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            5'd0:    op = OP_BOUNDS;
            5'd1:    op = OP_MUL_CH;
            5'd2:    op = OP_MUL_CHW;
            5'd3:    op = OP_MUL_RW;
            5'd4:    op = OP_ADD_FT;
            5'd5:    op = OP_ADD_FS;
            5'd6:    op = OP_MUL_PLANE;
            5'd7:    op = OP_MUL_CP;
            5'd8:    op = OP_MUL_CPKW;
            5'd9:    op = OP_MUL_CPKH;
            5'd10:   op = OP_MUL_U;
            5'd11:   op = OP_ADD_PT;
            5'd12:   op = OP_MUL_KWP;
            5'd13:   op = OP_MUL_V;
            5'd14:   op = OP_ADD_PT;
            5'd15:   op = OP_ADD_PD;
            5'd16:   op = OP_FILL;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* src/irtg_if.sv */
`default_nettype none

interface irtg_req_if;
    logic                        valid;
    logic                        ready;
    logic [irtg_pkg::ROW_W-1:0]  padded_row;

    modport source (output valid, output padded_row, input ready);
    modport sink   (input valid, input padded_row, output ready);
endinterface

interface irtg_desc_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [irtg_pkg::ADDR_W-1:0] address;
    logic [irtg_pkg::BUF_W-1:0]  buffer_offset;
    logic [irtg_pkg::BUF_W-1:0]  length;
    logic                        last;

    modport source (output valid, output kind, output address, output buffer_offset,
                    output length, output last, input ready);
    modport sink   (input valid, input kind, input address, input buffer_offset,
                    input length, input last, output ready);
endinterface

`default_nettype wire

/* src/im2col_row_transfer_generator_unit.sv */
// Row transfer generator for stride-1 im2col.
// req (valid/ready) takes one padded row index per beat: channel * padded height + row.
// desc (valid/ready) returns the descriptors for that row, one beat per cycle when the
// receiver is ready: a zero-fill or a row fetch into the line buffer first, then one put
// segment per kernel column and valid kernel row. The final beat of a row carries last.
// The cfg port (cfg_we, cfg_index, cfg_data) writes geometry and base addresses; write it
// only while no row is in flight.
// After the req beat, a one-bit-per-cycle divider splits the row index into channel
// and row; a shared multiplier and adder then compute the base addresses and load the
// first descriptor, which desc then offers. Each row has 1 to 50 descriptors;
// req.ready stays low until the last beat of the current row is taken.
// A stalled desc beat holds its payload; the row sequencer waits on it.
// Reset clears the sequencer to idle and loads the register defaults: height, width and
// kernel sizes 1, padding 0, base addresses 0.
`default_nettype none

module im2col_row_transfer_generator_unit #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_DIM    = 1023,
    parameter int ADDR_BITS  = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [irtg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irtg_pkg::ADDR_W-1:0]     cfg_data,
    irtg_req_if.sink                        req,
    irtg_desc_if.source                     desc
);

    irtg_pkg::cfg_t        cfg_reg;
    irtg_pkg::cfg_t        cfg_next;
    irtg_pkg::op_t         op;
    irtg_pkg::dp_status_t  status;
    irtg_pkg::desc_t       dp_desc;
    logic                  ctl_in_ready;
    logic                  ctl_out_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                irtg_pkg::CFG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[irtg_pkg::DIM_W-1:0];
                irtg_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[irtg_pkg::DIM_W-1:0];
                irtg_pkg::CFG_PAD_ROWS:
                    cfg_next.pad_rows = cfg_data[irtg_pkg::PAD_W-1:0];
                irtg_pkg::CFG_PAD_COLS:
                    cfg_next.pad_cols = cfg_data[irtg_pkg::PAD_W-1:0];
                irtg_pkg::CFG_KERN_HEIGHT:
                    cfg_next.kern_height = cfg_data[irtg_pkg::KERN_W-1:0];
                irtg_pkg::CFG_KERN_WIDTH:
                    cfg_next.kern_width = cfg_data[irtg_pkg::KERN_W-1:0];
                irtg_pkg::CFG_SOURCE_BASE:
                    cfg_next.source_base = cfg_data;
                irtg_pkg::CFG_DEST_BASE:
                    cfg_next.dest_base = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height <= irtg_pkg::DIM_W'(1);
            cfg_reg.image_width  <= irtg_pkg::DIM_W'(1);
            cfg_reg.pad_rows     <= '0;
            cfg_reg.pad_cols     <= '0;
            cfg_reg.kern_height  <= irtg_pkg::KERN_W'(1);
            cfg_reg.kern_width   <= irtg_pkg::KERN_W'(1);
            cfg_reg.source_base  <= '0;
            cfg_reg.dest_base    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (ctl_in_ready),
        .out_valid (ctl_out_valid),
        .out_ready (desc.ready),
        .op        (op),
        .status    (status)
    );

    irtg_datapath #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_DIM    (MAX_DIM),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cfg        (cfg_reg),
        .padded_row (req.padded_row),
        .status     (status),
        .desc       (dp_desc)
    );

    assign req.ready          = ctl_in_ready;
    assign desc.valid         = ctl_out_valid;
    assign desc.kind          = dp_desc.kind;
    assign desc.address       = dp_desc.address;
    assign desc.buffer_offset = dp_desc.buffer_offset;
    assign desc.length        = dp_desc.length;
    assign desc.last          = dp_desc.last;

endmodule

`default_nettype wire

/* src/irtg_ctrl.sv */
`default_nettype none

module irtg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output irtg_pkg::op_t          op,
    input  irtg_pkg::dp_status_t   status
);

    irtg_pkg::state_t                 state_reg;
    irtg_pkg::state_t                 state_next;
    logic [irtg_pkg::STEP_W-1:0]      step_reg;
    logic [irtg_pkg::STEP_W-1:0]      step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irtg_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            irtg_pkg::S_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = irtg_pkg::S_DIV;
                end
            end
            irtg_pkg::S_DIV:
            begin
                if (step_reg == irtg_pkg::STEP_W'(irtg_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = irtg_pkg::S_CALC;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            irtg_pkg::S_CALC:
            begin
                if (step_reg == irtg_pkg::STEP_W'(irtg_pkg::CALC_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = irtg_pkg::S_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            irtg_pkg::S_EMIT:
            begin
                if (out_ready && status.last)
                begin
                    state_next = irtg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = irtg_pkg::S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        op        = irtg_pkg::OP_NONE;
        case (state_reg)
            irtg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = irtg_pkg::OP_LOAD;
                end
            end
            irtg_pkg::S_DIV:
            begin
                op = irtg_pkg::OP_DIV;
            end
            irtg_pkg::S_CALC:
            begin
                op = irtg_pkg::calc_op(step_reg);
            end
            irtg_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready && !status.last)
                begin
                    op = irtg_pkg::OP_NEXT_PUT;
                end
            end
            default:
            begin
                op = irtg_pkg::OP_NONE;
            end
        endcase
    end

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == irtg_pkg::S_DIV) && (step_reg == '0))
        else $error("accepted row did not start division");

    a_div_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == irtg_pkg::S_DIV) |->
            (step_reg < irtg_pkg::STEP_W'(irtg_pkg::DIV_STEPS)))
        else $error("division step out of range");

    a_last_beat_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.last) |=> (state_reg == irtg_pkg::S_IDLE))
        else $error("final beat did not return to idle");

endmodule

`default_nettype wire

/* src/irtg_datapath.sv */
`default_nettype none

module irtg_datapath #(
    parameter int MAX_KERNEL = 7,
    parameter int MAX_DIM    = 1023,
    parameter int ADDR_BITS  = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irtg_pkg::op_t               op,
    input  irtg_pkg::cfg_t              cfg,
    input  logic [irtg_pkg::ROW_W-1:0]  padded_row,
    output irtg_pkg::dp_status_t        status,
    output irtg_pkg::desc_t             desc
);

    localparam int DW = irtg_pkg::DIM_W;
    localparam int KW = irtg_pkg::KERN_W;
    localparam int AW = irtg_pkg::ADDR_W;
    localparam int BW = irtg_pkg::BUF_W;
    localparam int SW = irtg_pkg::SIGN_W;
    localparam int RW = irtg_pkg::ROW_W;
    localparam int PW = irtg_pkg::PLANE_W;
    localparam int QW = irtg_pkg::KWP_W;
    localparam int MB = irtg_pkg::MUL_B_W;

    localparam int DIM_LIM = (MAX_DIM > (1 << DW) - 1) ? (1 << DW) - 1 : MAX_DIM;
    localparam logic [DW-1:0] DIM_CAP  = DW'(DIM_LIM);
    localparam logic [KW-1:0] KERN_CAP = KW'(MAX_KERNEL);
    localparam int AW_EFF = (ADDR_BITS > AW) ? AW : ADDR_BITS;
    localparam logic [AW-1:0] ADDR_MASK = AW'((65'd1 << AW_EFF) - 65'd1);

    logic [DW-1:0]        h;
    logic [DW-1:0]        w;
    logic [KW-1:0]        kh;
    logic [KW-1:0]        kw;
    logic [BW-1:0]        ph;
    logic [BW-1:0]        bufw;
    logic signed [SW-1:0] oh;
    logic signed [SW-1:0] ow;
    logic                 dims_ok;
    logic [BW-1:0]        oh_u;
    logic [BW-1:0]        ow_u;

    logic [RW-1:0]        quo_reg, quo_next;
    logic [BW-1:0]        rem_reg, rem_next;
    logic                 is_img_reg, is_img_next;
    logic                 any_put_reg, any_put_next;
    logic [KW-1:0]        klo_reg, klo_next;
    logic [KW-1:0]        khi_reg, khi_next;
    logic [AW-1:0]        fa_reg, fa_next;
    logic [AW-1:0]        tmp_reg, tmp_next;
    logic [AW-1:0]        pa_reg, pa_next;
    logic [PW-1:0]        plane_reg, plane_next;
    logic [QW-1:0]        kwp_reg, kwp_next;
    logic [QW-1:0]        delta_reg, delta_next;
    irtg_pkg::kind_t      kind_reg, kind_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [BW-1:0]        off_reg, off_next;
    logic [BW-1:0]        len_reg, len_next;
    logic                 last_reg, last_next;
    logic [KW-1:0]        c_reg, c_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [AW-1:0]        col_reg, col_next;

    logic [BW:0]          div_trial;
    logic                 div_ge;
    logic signed [BW+1:0] klo_raw;
    logic [KW-1:0]        khi_c;
    logic [AW-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic [AW+MB-1:0]     mul_full;
    logic [AW-1:0]        mul_p;
    logic [AW-1:0]        add_a;
    logic [AW-1:0]        add_b;
    logic [AW-1:0]        add_s;
    logic [AW-1:0]        col_step;
    logic [AW-1:0]        row_step;
    logic [KW-1:0]        c_inc;
    logic [KW-1:0]        k_inc;
    logic [KW-1:0]        kw_m1;

    always_comb
    begin
        if (cfg.image_height == '0)
            h = DW'(1);
        else if (32'(cfg.image_height) > MAX_DIM)
            h = DIM_CAP;
        else
            h = cfg.image_height;
        if (cfg.image_width == '0)
            w = DW'(1);
        else if (32'(cfg.image_width) > MAX_DIM)
            w = DIM_CAP;
        else
            w = cfg.image_width;
        if (cfg.kern_height == '0)
            kh = KW'(1);
        else if (cfg.kern_height > KERN_CAP)
            kh = KERN_CAP;
        else
            kh = cfg.kern_height;
        if (cfg.kern_width == '0)
            kw = KW'(1);
        else if (cfg.kern_width > KERN_CAP)
            kw = KERN_CAP;
        else
            kw = cfg.kern_width;
    end

    assign ph      = BW'(h) + {cfg.pad_rows, 1'b0};
    assign bufw    = BW'(w) + {cfg.pad_cols, 1'b0};
    assign oh      = $signed(SW'(ph) - SW'(kh) + SW'(1));
    assign ow      = $signed(SW'(bufw) - SW'(kw) + SW'(1));
    assign dims_ok = (oh > 0) && (ow > 0);
    assign oh_u    = oh[BW-1:0];
    assign ow_u    = ow[BW-1:0];
    assign kw_m1   = kw - KW'(1);

    assign div_trial = {rem_reg, quo_reg[RW-1]};
    assign div_ge    = div_trial >= {1'b0, ph};

    assign klo_raw = $signed({2'b00, rem_reg}) - $signed({oh[SW-1], oh}) + 13'sd1;
    assign khi_c   = (rem_reg < BW'(kh - KW'(1))) ? rem_reg[KW-1:0] : kh - KW'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            irtg_pkg::OP_MUL_CH:
            begin
                mul_a = AW'(quo_reg);
                mul_b = MB'(h);
            end
            irtg_pkg::OP_MUL_CHW:
            begin
                mul_a = fa_reg;
                mul_b = MB'(w);
            end
            irtg_pkg::OP_MUL_RW:
            begin
                mul_a = AW'(rem_reg - BW'(cfg.pad_rows));
                mul_b = MB'(w);
            end
            irtg_pkg::OP_MUL_PLANE:
            begin
                mul_a = AW'(oh_u);
                mul_b = MB'(ow_u);
            end
            irtg_pkg::OP_MUL_CP:
            begin
                mul_a = AW'(quo_reg);
                mul_b = plane_reg;
            end
            irtg_pkg::OP_MUL_CPKW:
            begin
                mul_a = pa_reg;
                mul_b = MB'(kw);
            end
            irtg_pkg::OP_MUL_CPKH:
            begin
                mul_a = pa_reg;
                mul_b = MB'(kh);
            end
            irtg_pkg::OP_MUL_U:
            begin
                mul_a = AW'(rem_reg - BW'(klo_reg));
                mul_b = MB'(ow_u);
            end
            irtg_pkg::OP_MUL_KWP:
            begin
                mul_a = AW'(plane_reg);
                mul_b = MB'(kw);
            end
            irtg_pkg::OP_MUL_V:
            begin
                mul_a = AW'(kwp_reg);
                mul_b = MB'(klo_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[AW-1:0];

    always_comb
    begin
        add_a = fa_reg;
        add_b = tmp_reg;
        case (op)
            irtg_pkg::OP_ADD_FT:
            begin
                add_a = fa_reg;
                add_b = tmp_reg;
            end
            irtg_pkg::OP_ADD_FS:
            begin
                add_a = fa_reg;
                add_b = cfg.source_base;
            end
            irtg_pkg::OP_ADD_PT:
            begin
                add_a = pa_reg;
                add_b = tmp_reg;
            end
            irtg_pkg::OP_ADD_PD:
            begin
                add_a = pa_reg;
                add_b = cfg.dest_base;
            end
            default:
            begin
                add_a = fa_reg;
                add_b = tmp_reg;
            end
        endcase
    end

    assign add_s    = add_a + add_b;
    assign col_step = col_reg + AW'(plane_reg);
    assign row_step = addr_reg + AW'(delta_reg);
    assign c_inc    = c_reg + KW'(1);
    assign k_inc    = k_reg + KW'(1);

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        is_img_next  = is_img_reg;
        any_put_next = any_put_reg;
        klo_next     = klo_reg;
        khi_next     = khi_reg;
        fa_next      = fa_reg;
        tmp_next     = tmp_reg;
        pa_next      = pa_reg;
        plane_next   = plane_reg;
        kwp_next     = kwp_reg;
        delta_next   = delta_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        off_next     = off_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        col_next     = col_reg;
        case (op)
            irtg_pkg::OP_LOAD:
            begin
                quo_next = padded_row;
                rem_next = '0;
            end
            irtg_pkg::OP_DIV:
            begin
                quo_next = {quo_reg[RW-2:0], div_ge};
                rem_next = div_ge ? BW'(div_trial - {1'b0, ph}) : div_trial[BW-1:0];
            end
            irtg_pkg::OP_BOUNDS:
            begin
                is_img_next  = (rem_reg >= BW'(cfg.pad_rows))
                               && (rem_reg < BW'(cfg.pad_rows) + BW'(h));
                any_put_next = dims_ok && (klo_raw <= $signed({10'd0, khi_c}));
                klo_next     = (klo_raw <= 13'sd0) ? '0 : klo_raw[KW-1:0];
                khi_next     = khi_c;
            end
            irtg_pkg::OP_MUL_CH, irtg_pkg::OP_MUL_CHW:
            begin
                fa_next = mul_p;
            end
            irtg_pkg::OP_MUL_RW, irtg_pkg::OP_MUL_U:
            begin
                tmp_next = mul_p;
            end
            irtg_pkg::OP_MUL_PLANE:
            begin
                plane_next = mul_p[PW-1:0];
            end
            irtg_pkg::OP_MUL_CP, irtg_pkg::OP_MUL_CPKW, irtg_pkg::OP_MUL_CPKH:
            begin
                pa_next = mul_p;
            end
            irtg_pkg::OP_MUL_KWP:
            begin
                kwp_next = mul_p[QW-1:0];
            end
            irtg_pkg::OP_MUL_V:
            begin
                tmp_next   = mul_p;
                delta_next = kwp_reg - QW'(ow_u);
            end
            irtg_pkg::OP_ADD_FT, irtg_pkg::OP_ADD_FS:
            begin
                fa_next = add_s;
            end
            irtg_pkg::OP_ADD_PT, irtg_pkg::OP_ADD_PD:
            begin
                pa_next = add_s;
            end
            irtg_pkg::OP_FILL:
            begin
                last_next = !any_put_reg;
                if (is_img_reg)
                begin
                    kind_next = irtg_pkg::KIND_FETCH;
                    addr_next = fa_reg;
                    off_next  = BW'(cfg.pad_cols);
                    len_next  = BW'(w);
                end
                else
                begin
                    kind_next = irtg_pkg::KIND_ZERO;
                    addr_next = '0;
                    off_next  = '0;
                    len_next  = bufw;
                end
            end
            irtg_pkg::OP_NEXT_PUT:
            begin
                len_next = ow_u;
                if (kind_reg != irtg_pkg::KIND_PUT)
                begin
                    kind_next = irtg_pkg::KIND_PUT;
                    addr_next = pa_reg;
                    col_next  = pa_reg;
                    c_next    = '0;
                    k_next    = klo_reg;
                    off_next  = '0;
                    last_next = (kw_m1 == '0) && (klo_reg == khi_reg);
                end
                else if (k_reg == khi_reg)
                begin
                    c_next    = c_inc;
                    k_next    = klo_reg;
                    col_next  = col_step;
                    addr_next = col_step;
                    off_next  = BW'(c_inc);
                    last_next = (c_inc == kw_m1) && (klo_reg == khi_reg);
                end
                else
                begin
                    k_next    = k_inc;
                    addr_next = row_step;
                    last_next = (c_reg == kw_m1) && (k_inc == khi_reg);
                end
            end
            default:
            begin
                quo_next = quo_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        is_img_reg  <= is_img_next;
        any_put_reg <= any_put_next;
        klo_reg     <= klo_next;
        khi_reg     <= khi_next;
        fa_reg      <= fa_next;
        tmp_reg     <= tmp_next;
        pa_reg      <= pa_next;
        plane_reg   <= plane_next;
        kwp_reg     <= kwp_next;
        delta_reg   <= delta_next;
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
        off_reg     <= off_next;
        len_reg     <= len_next;
        last_reg    <= last_next;
        c_reg       <= c_next;
        k_reg       <= k_next;
        col_reg     <= col_next;
    end

    assign status.last        = last_reg;
    assign desc.kind          = kind_reg;
    assign desc.address       = addr_reg & ADDR_MASK;
    assign desc.buffer_offset = off_reg;
    assign desc.length        = len_reg;
    assign desc.last          = last_reg;

    a_load_clears_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (op == irtg_pkg::OP_LOAD) |=> (rem_reg == '0))
        else $error("remainder not cleared on load");

    a_div_shifts_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (op == irtg_pkg::OP_DIV) |=> (quo_reg[RW-1:1] == $past(quo_reg[RW-2:0])))
        else $error("quotient did not shift on division step");

    a_fill_not_put: assert property (@(posedge clk) disable iff (!rst_n)
        (op == irtg_pkg::OP_FILL) |=> (kind_reg != irtg_pkg::KIND_PUT))
        else $error("fill beat tagged as put");

    a_next_is_put: assert property (@(posedge clk) disable iff (!rst_n)
        (op == irtg_pkg::OP_NEXT_PUT) |=> (kind_reg == irtg_pkg::KIND_PUT))
        else $error("advance produced a non-put beat");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;

    localparam int DIM_MAX  = 1023;
    localparam int KERN_MAX = 7;

    class desc_scoreboard;
        logic [irtg_pkg::DIM_W-1:0]  height;
        logic [irtg_pkg::DIM_W-1:0]  width;
        logic [irtg_pkg::PAD_W-1:0]  pad_rows;
        logic [irtg_pkg::PAD_W-1:0]  pad_cols;
        logic [irtg_pkg::KERN_W-1:0] kern_h;
        logic [irtg_pkg::KERN_W-1:0] kern_w;
        logic [irtg_pkg::ADDR_W-1:0] src_base;
        logic [irtg_pkg::ADDR_W-1:0] dst_base;
        irtg_pkg::desc_t             pending[$];
        int                          failures;

        function new();
            height   = irtg_pkg::DIM_W'(1);
            width    = irtg_pkg::DIM_W'(1);
            pad_rows = '0;
            pad_cols = '0;
            kern_h   = irtg_pkg::KERN_W'(1);
            kern_w   = irtg_pkg::KERN_W'(1);
            src_base = '0;
            dst_base = '0;
            failures = 0;
        endfunction

        static function longint fit(longint v, longint hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function longint padded_height();
            return fit(longint'(height), DIM_MAX) + 2 * longint'(pad_rows);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%0t %s", $time, msg);
        endfunction

        function void write_reg(irtg_pkg::cfg_index_t idx,
                                logic [irtg_pkg::ADDR_W-1:0] data);
            case (idx)
                irtg_pkg::CFG_IMAGE_HEIGHT: height   = data[irtg_pkg::DIM_W-1:0];
                irtg_pkg::CFG_IMAGE_WIDTH:  width    = data[irtg_pkg::DIM_W-1:0];
                irtg_pkg::CFG_PAD_ROWS:     pad_rows = data[irtg_pkg::PAD_W-1:0];
                irtg_pkg::CFG_PAD_COLS:     pad_cols = data[irtg_pkg::PAD_W-1:0];
                irtg_pkg::CFG_KERN_HEIGHT:  kern_h   = data[irtg_pkg::KERN_W-1:0];
                irtg_pkg::CFG_KERN_WIDTH:   kern_w   = data[irtg_pkg::KERN_W-1:0];
                irtg_pkg::CFG_SOURCE_BASE:  src_base = data;
                irtg_pkg::CFG_DEST_BASE:    dst_base = data;
                default:                    ;
            endcase
        endfunction

        function void note_row(logic [irtg_pkg::ROW_W-1:0] row);
            longint          h, w, kh, kw, pr, pc, ph, chan, r, oh, ow, plane, cbase;
            int              total;
            int              done;
            irtg_pkg::desc_t d;
            h  = fit(longint'(height), DIM_MAX);
            w  = fit(longint'(width), DIM_MAX);
            kh = fit(longint'(kern_h), KERN_MAX);
            kw = fit(longint'(kern_w), KERN_MAX);
            pr = longint'(pad_rows);
            pc = longint'(pad_cols);
            ph = h + 2 * pr;
            chan = longint'(row) / ph;
            r  = longint'(row) % ph;
            oh = h + 2 * pr - kh + 1;
            ow = w + 2 * pc - kw + 1;
            total = 0;
            if (oh > 0 && ow > 0)
                for (int k = 0; k < kh; k++)
                    if (r - k >= 0 && r - k < oh)
                        total++;
            total = total * int'(kw);
            if (r < pr || r >= pr + h)
            begin
                d.kind          = irtg_pkg::KIND_ZERO;
                d.address       = '0;
                d.buffer_offset = '0;
                d.length        = irtg_pkg::BUF_W'(w + 2 * pc);
            end
            else
            begin
                d.kind          = irtg_pkg::KIND_FETCH;
                d.address       = irtg_pkg::ADDR_W'(longint'(src_base) + chan * h * w
                                                    + (r - pr) * w);
                d.buffer_offset = irtg_pkg::BUF_W'(pc);
                d.length        = irtg_pkg::BUF_W'(w);
            end
            d.last = (total == 0);
            pending.push_back(d);
            plane = oh * ow;
            cbase = longint'(dst_base) + chan * plane * kw * kh;
            done  = 0;
            for (int c = 0; c < kw && total > 0; c++)
                for (int k = 0; k < kh; k++)
                    if (r - k >= 0 && r - k < oh)
                    begin
                        done++;
                        d.kind          = irtg_pkg::KIND_PUT;
                        d.address       = irtg_pkg::ADDR_W'(cbase + (c + k * kw) * plane
                                                            + (r - k) * ow);
                        d.buffer_offset = irtg_pkg::BUF_W'(c);
                        d.length        = irtg_pkg::BUF_W'(ow);
                        d.last          = (done == total);
                        pending.push_back(d);
                    end
        endfunction

        function void check_desc(irtg_pkg::desc_t got);
            irtg_pkg::desc_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected beat kind=%0d addr=%h off=%0d len=%0d last=%0b",
                               got.kind, got.address, got.buffer_offset, got.length,
                               got.last));
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.buffer_offset !== want.buffer_offset || got.length !== want.length ||
                got.last !== want.last)
                flag($sformatf({"mismatch: expected kind=%0d addr=%h off=%0d len=%0d ",
                                "last=%0b, got kind=%0d addr=%h off=%0d len=%0d last=%0b"},
                               want.kind, want.address, want.buffer_offset, want.length,
                               want.last, got.kind, got.address, got.buffer_offset,
                               got.length, got.last));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [irtg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [irtg_pkg::ADDR_W-1:0]    cfg_data;
    int                             src_idle;
    int                             snk_idle;
    irtg_pkg::desc_t                beat;
    desc_scoreboard                 sb = new;

    irtg_req_if  req_ch ();
    irtg_desc_if desc_ch ();

    im2col_row_transfer_generator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .desc      (desc_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        desc_ch.ready = ($urandom_range(0, 99) >= snk_idle);

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_row(req_ch.padded_row);
        if (rst_n && desc_ch.valid && desc_ch.ready)
        begin
            beat.kind          = irtg_pkg::kind_t'(desc_ch.kind);
            beat.address       = desc_ch.address;
            beat.buffer_offset = desc_ch.buffer_offset;
            beat.length        = desc_ch.length;
            beat.last          = desc_ch.last;
            sb.check_desc(beat);
        end
    end

    task automatic send_row(input logic [irtg_pkg::ROW_W-1:0] row);
        while ($urandom_range(0, 99) < src_idle)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.padded_row = row;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input irtg_pkg::cfg_index_t idx,
                             input logic [irtg_pkg::ADDR_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic set_geometry(input logic [irtg_pkg::ADDR_W-1:0] h,
                                input logic [irtg_pkg::ADDR_W-1:0] w,
                                input logic [irtg_pkg::ADDR_W-1:0] pr,
                                input logic [irtg_pkg::ADDR_W-1:0] pc,
                                input logic [irtg_pkg::ADDR_W-1:0] kh,
                                input logic [irtg_pkg::ADDR_W-1:0] kw,
                                input logic [irtg_pkg::ADDR_W-1:0] src,
                                input logic [irtg_pkg::ADDR_W-1:0] dst);
        write_reg(irtg_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(irtg_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(irtg_pkg::CFG_PAD_ROWS, pr);
        write_reg(irtg_pkg::CFG_PAD_COLS, pc);
        write_reg(irtg_pkg::CFG_KERN_HEIGHT, kh);
        write_reg(irtg_pkg::CFG_KERN_WIDTH, kw);
        write_reg(irtg_pkg::CFG_SOURCE_BASE, src);
        write_reg(irtg_pkg::CFG_DEST_BASE, dst);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [irtg_pkg::ADDR_W-1:0] rand48();
        return irtg_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    // set unused upper data bits at random half the time
    function automatic logic [irtg_pkg::ADDR_W-1:0] noisy(logic [irtg_pkg::ADDR_W-1:0] v,
                                                           int bits);
        if ($urandom_range(0, 1))
            return v;
        return (rand48() & ~((48'd1 << bits) - 48'd1)) | v;
    endfunction

    task automatic random_config();
        logic [irtg_pkg::ADDR_W-1:0] h;
        logic [irtg_pkg::ADDR_W-1:0] w;
        case ($urandom_range(0, 9))
            0:
            begin
                h = irtg_pkg::ADDR_W'(DIM_MAX);
                w = irtg_pkg::ADDR_W'($urandom_range(0, DIM_MAX));
            end
            1:
            begin
                h = irtg_pkg::ADDR_W'($urandom_range(0, DIM_MAX));
                w = irtg_pkg::ADDR_W'(DIM_MAX);
            end
            2:
            begin
                h = irtg_pkg::ADDR_W'($urandom_range(0, 1));
                w = irtg_pkg::ADDR_W'($urandom_range(0, 1));
            end
            default:
            begin
                h = irtg_pkg::ADDR_W'($urandom_range(1, 12));
                w = irtg_pkg::ADDR_W'($urandom_range(1, 16));
            end
        endcase
        set_geometry(noisy(h, irtg_pkg::DIM_W), noisy(w, irtg_pkg::DIM_W),
                     noisy(irtg_pkg::ADDR_W'($urandom_range(0, 7)), irtg_pkg::PAD_W),
                     noisy(irtg_pkg::ADDR_W'($urandom_range(0, 7)), irtg_pkg::PAD_W),
                     noisy(irtg_pkg::ADDR_W'($urandom_range(0, 7)), irtg_pkg::KERN_W),
                     noisy(irtg_pkg::ADDR_W'($urandom_range(0, 7)), irtg_pkg::KERN_W),
                     rand48(), rand48());
    endtask

    function automatic logic [irtg_pkg::ROW_W-1:0] pick_row();
        longint ph;
        longint v;
        ph = sb.padded_height();
        case ($urandom_range(0, 15))
            0:       return irtg_pkg::ROW_W'($urandom);
            1:       return '1;
            default:
            begin
                v = longint'($urandom_range(0, 40)) * ph
                    + longint'($urandom_range(0, 32'(ph - 1)));
                return irtg_pkg::ROW_W'(v);
            end
        endcase
    endfunction

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.padded_row  = '0;
        desc_ch.ready      = 1'b0;
        src_idle           = 28;
        snk_idle           = 62;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_row(21'd0);
        send_row('1);
        send_row(21'd12345);
        drain();

        set_geometry(48'd4, 48'd5, 48'd2, 48'd3, 48'd3, 48'd2,
                     48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
        for (int i = 0; i < 8; i++)
            send_row(irtg_pkg::ROW_W'(i));
        send_row(irtg_pkg::ROW_W'(3 * 8 + 4));
        drain();

        set_geometry(irtg_pkg::ADDR_W'(DIM_MAX), irtg_pkg::ADDR_W'(DIM_MAX),
                     48'd7, 48'd7, 48'd7, 48'd7, '1, '1);
        send_row(21'd7);
        send_row(21'd500);
        send_row(21'd1036);
        send_row('1);
        drain();

        // zero dimensions with junk above the register bits
        set_geometry(48'hFFFF_FFFF_FC00, 48'hFFFF_FFFF_FC00, 48'hFFFF_FFFF_FFF8,
                     48'hFFFF_FFFF_FFF8, 48'hFFFF_FFFF_FFF8, 48'hFFFF_FFFF_FFF8,
                     48'h0, 48'h0);
        send_row(21'd5);
        send_row(21'h0AAAAA);
        drain();

        // kernel taller than the padded image
        set_geometry(48'd2, 48'd3, 48'd0, 48'd1, 48'd7, 48'd2, rand48(), rand48());
        send_row(21'd0);
        send_row(21'd1);
        send_row(21'd5);
        drain();

        // kernel wider than the padded image
        set_geometry(48'd3, 48'd1, 48'd0, 48'd0, 48'd1, 48'd5, rand48(), rand48());
        send_row(21'd2);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            if (phase == 1)
            begin
                src_idle = 62;
                snk_idle = 28;
            end
            if (phase == 2)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            for (int g = 0; g < 4; g++)
            begin
                drain();
                random_config();
                repeat (37) send_row(pick_row());
            end
        end

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
